@@ src/ecam_pkg.sv @@
// Shared types, constants and tables for the Euler camera orientation block.
package ecam_pkg;

  // Angles in 1/65536 degree, wide enough for a stored angle plus one step.
  localparam logic signed [28:0] FullTurn    = 29'sd23592960;
  localparam logic signed [28:0] HalfTurn    = 29'sd11796480;
  localparam logic signed [28:0] QuarterTurn = 29'sd5898240;
  localparam logic signed [28:0] PitchLimit  = 29'sd5832704;
  localparam logic signed [24:0] YawReset    = -25'sd5898240;

  // Rotation engine settings, Q1.30 start value.
  localparam int unsigned CordicSteps = 18;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] RegSensitivity = 2'd0;
  localparam logic [1:0] RegUpX         = 2'd1;
  localparam logic [1:0] RegUpY         = 2'd2;
  localparam logic [1:0] RegUpZ         = 2'd3;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic        [15:0] sens;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } cfg_t;

  // One classified item queued between the front and the back.
  typedef struct packed {
    logic signed [28:0] d_yaw;
    logic signed [28:0] d_pitch;
    logic               limit;
    logic               absm;
    logic signed [31:0] mv_x;
    logic signed [31:0] mv_y;
    logic signed [31:0] mv_z;
  } item_t;

  // Arctangent of 2^-i in 1/65536 degree.
  function automatic logic signed [25:0] atan_lut(input logic [4:0] i);
    logic signed [25:0] r;
    case (i)
      5'd0:    r = 26'sd2949120;
      5'd1:    r = 26'sd1740967;
      5'd2:    r = 26'sd919879;
      5'd3:    r = 26'sd466945;
      5'd4:    r = 26'sd234379;
      5'd5:    r = 26'sd117304;
      5'd6:    r = 26'sd58666;
      5'd7:    r = 26'sd29335;
      5'd8:    r = 26'sd14668;
      5'd9:    r = 26'sd7334;
      5'd10:   r = 26'sd3667;
      5'd11:   r = 26'sd1833;
      5'd12:   r = 26'sd917;
      5'd13:   r = 26'sd458;
      5'd14:   r = 26'sd229;
      5'd15:   r = 26'sd115;
      5'd16:   r = 26'sd57;
      5'd17:   r = 26'sd29;
      default: r = 26'sd0;
    endcase
    return r;
  endfunction

endpackage

@@ src/ecam_front.sv @@
// Front end: accepts pointer items and turns offsets into angle steps.
module ecam_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // offset_x, offset_y, move_x, move_y, move_z
  input  logic [127:0]         s_axis_tdata_i,
  // limit_pitch, absolute_move
  input  logic [1:0]           s_axis_tuser_i,
  input  logic [15:0]          sens_i,
  input  logic                 full_i,
  output logic                 push_o,
  output ecam_pkg::item_t      item_o
);
  import ecam_pkg::*;

  logic signed [15:0] off_x, off_y;
  logic signed [32:0] prod_x, prod_y;
  logic signed [32:0] rnd_x, rnd_y;
  logic               busy_q;

  assign off_x = s_axis_tdata_i[15:0];
  assign off_y = s_axis_tdata_i[31:16];

  // Scale both offsets by the gain, round half up to 1/65536 degree.
  assign prod_x = off_x * $signed({1'b0, sens_i});
  assign prod_y = off_y * $signed({1'b0, sens_i});
  assign rnd_x  = (prod_x + 33'sd8) >>> 4;
  assign rnd_y  = (prod_y + 33'sd8) >>> 4;

  // Track that the queue has been seen since reset before taking transfers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= 1'b1;
    end
  end

  assign s_axis_tready_o = busy_q && !full_i;
  assign push_o          = s_axis_tvalid_i && s_axis_tready_o;

  // Classify the transfer into a queue entry.
  always_comb begin
    item_o.d_yaw   = rnd_x[28:0];
    item_o.d_pitch = rnd_y[28:0];
    item_o.limit   = s_axis_tuser_i[0];
    item_o.absm    = s_axis_tuser_i[1];
    item_o.mv_x    = s_axis_tdata_i[63:32];
    item_o.mv_y    = s_axis_tdata_i[95:64];
    item_o.mv_z    = s_axis_tdata_i[127:96];
  end

endmodule

@@ src/ecam_fifo.sv @@
// Two-entry queue between the front end and the back end.
module ecam_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ecam_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output ecam_pkg::item_t item_o,
  output logic            empty_o
);
  import ecam_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

@@ src/ecam_back.sv @@
// Back end: angle and position update, sine and cosine, cross products and
// normalization on one shared multiplier, square root and divider.
module ecam_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ecam_pkg::cfg_t       cfg_i,
  input  logic                 empty_i,
  input  ecam_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // front xyz, right xyz, up xyz, position xyz
  output logic [239:0]         m_axis_tdata_o
);
  import ecam_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StWrap   = 4'd1;
  localparam logic [3:0] StCordic = 4'd2;
  localparam logic [3:0] StFront  = 4'd3;
  localparam logic [3:0] StSq     = 4'd4;
  localparam logic [3:0] StSqrt   = 4'd5;
  localparam logic [3:0] StDiv    = 4'd6;
  localparam logic [3:0] StCross  = 4'd7;
  localparam logic [3:0] StOut    = 4'd8;

  logic [3:0] st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] pass_q, pass_d;
  logic [1:0] comp_q, comp_d;

  logic signed [24:0] yaw_q, yaw_d, pit_q, pit_d;
  logic signed [31:0] pos_q [3];
  logic signed [31:0] pos_d [3];
  logic signed [28:0] wa_q, wa_d, wb_q, wb_d;
  logic               lim_q, lim_d;

  logic signed [33:0] xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic signed [25:0] za_q, za_d, zb_q, zb_d;
  logic               nga_q, nga_d, ngb_q, ngb_d;

  logic signed [31:0] vec_q [3];
  logic signed [31:0] vec_d [3];
  logic signed [31:0] tmp_q, tmp_d;
  logic signed [15:0] vres_q [3][3];
  logic signed [15:0] vres_d [3][3];

  logic [63:0] acc_q, acc_d, n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic [32:0] len_q, len_d;
  logic [49:0] rem_q, rem_d;
  logic [15:0] quo_q, quo_d;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  logic               ov_q, ov_d;
  logic [239:0]       od_q, od_d;

  // Shared datapath helpers.
  logic [1:0]         rd_idx;
  logic signed [31:0] rd_v;
  logic [32:0]        rd_abs;
  logic signed [33:0] sa, ca, sb, cb;
  logic signed [65:0] rnd;
  logic signed [32:0] psum [3];
  logic signed [31:0] mvv [3];
  logic signed [15:0] xa_op [3];
  logic signed [15:0] xb_op [3];
  logic [3:0]         shk;
  logic [49:0]        dsh;
  logic [63:0]        rb;
  logic signed [28:0] pcl, fa, fb;
  logic [2:0]         jj;

  assign rd_v   = vec_q[rd_idx];
  assign rd_abs = rd_v[31] ? 33'(-$signed({rd_v[31], rd_v})) : 33'({rd_v[31], rd_v});
  assign sa     = nga_q ? -ya_q : ya_q;
  assign ca     = nga_q ? -xa_q : xa_q;
  assign sb     = ngb_q ? -yb_q : yb_q;
  assign cb     = ngb_q ? -xb_q : xb_q;
  assign rnd    = (prod_q + (66'sd1 <<< 29)) >>> 30;
  assign mvv[0] = item_i.mv_x;
  assign mvv[1] = item_i.mv_y;
  assign mvv[2] = item_i.mv_z;
  assign shk    = 4'(6'd16 - cnt_q);
  assign dsh    = 50'({len_q, 1'b0}) << shk;
  assign rb     = res_q + bit_q;
  assign jj     = 3'(cnt_q - 6'd1);

  // Cross product operands: front x up in the first cross, right x front next.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xa_op[k] = (pass_q == 2'd1) ? vres_q[0][k] : vres_q[1][k];
    end
    xb_op[0] = (pass_q == 2'd1) ? cfg_i.up_x : vres_q[0][0];
    xb_op[1] = (pass_q == 2'd1) ? cfg_i.up_y : vres_q[0][1];
    xb_op[2] = (pass_q == 2'd1) ? cfg_i.up_z : vres_q[0][2];
  end

  // Saturating position sums.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      psum[k] = {pos_q[k][31], pos_q[k]} + {mvv[k][31], mvv[k]};
    end
  end

  // Pitch clamp and folding of both angles into plus or minus 90 degrees.
  always_comb begin
    pcl = wb_q;
    if (lim_q && wb_q > PitchLimit) begin
      pcl = PitchLimit;
    end else if (lim_q && wb_q < -PitchLimit) begin
      pcl = -PitchLimit;
    end
    fa = wa_q;
    if (wa_q > QuarterTurn) begin
      fa = wa_q - HalfTurn;
    end else if (wa_q < -QuarterTurn) begin
      fa = wa_q + HalfTurn;
    end
    fb = pcl;
    if (pcl > QuarterTurn) begin
      fb = pcl - HalfTurn;
    end else if (pcl < -QuarterTurn) begin
      fb = pcl + HalfTurn;
    end
  end

  // Sequencer.
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    pass_d = pass_q;
    comp_d = comp_q;
    yaw_d  = yaw_q;
    pit_d  = pit_q;
    pos_d  = pos_q;
    wa_d   = wa_q;
    wb_d   = wb_q;
    lim_d  = lim_q;
    xa_d   = xa_q;
    ya_d   = ya_q;
    xb_d   = xb_q;
    yb_d   = yb_q;
    za_d   = za_q;
    zb_d   = zb_q;
    nga_d  = nga_q;
    ngb_d  = ngb_q;
    vec_d  = vec_q;
    tmp_d  = tmp_q;
    vres_d = vres_q;
    acc_d  = acc_q;
    n_d    = n_q;
    res_d  = res_q;
    bit_d  = bit_q;
    len_d  = len_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ov_d   = ov_q;
    od_d   = od_q;
    pop_o  = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    rd_idx = comp_q;

    if (ov_q && m_axis_tready_i) begin
      ov_d = 1'b0;
    end

    case (st_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          wa_d  = 29'(yaw_q) + item_i.d_yaw;
          wb_d  = 29'(pit_q) + item_i.d_pitch;
          lim_d = item_i.limit;
          for (int k = 0; k < 3; k++) begin
            if (item_i.absm) begin
              pos_d[k] = mvv[k];
            end else if (psum[k] > 33'sd2147483647) begin
              pos_d[k] = 32'sh7fffffff;
            end else if (psum[k] < -33'sd2147483648) begin
              pos_d[k] = 32'sh80000000;
            end else begin
              pos_d[k] = psum[k][31:0];
            end
          end
          st_d = StWrap;
        end
      end

      // Bring both sums into [-180, 180) one turn per cycle.
      StWrap: begin
        if (wa_q >= HalfTurn) begin
          wa_d = wa_q - FullTurn;
        end else if (wa_q < -HalfTurn) begin
          wa_d = wa_q + FullTurn;
        end
        if (wb_q >= HalfTurn) begin
          wb_d = wb_q - FullTurn;
        end else if (wb_q < -HalfTurn) begin
          wb_d = wb_q + FullTurn;
        end
        if (wa_q < HalfTurn && wa_q >= -HalfTurn && wb_q < HalfTurn && wb_q >= -HalfTurn) begin
          yaw_d = wa_q[24:0];
          pit_d = pcl[24:0];
          za_d  = fa[25:0];
          zb_d  = fb[25:0];
          nga_d = (fa != wa_q);
          ngb_d = (fb != pcl);
          xa_d  = CordicGain;
          ya_d  = '0;
          xb_d  = CordicGain;
          yb_d  = '0;
          cnt_d = '0;
          st_d  = StCordic;
        end
      end

      // One rotation step for yaw and pitch each cycle.
      StCordic: begin
        if (!za_q[25]) begin
          xa_d = xa_q - (ya_q >>> cnt_q[4:0]);
          ya_d = ya_q + (xa_q >>> cnt_q[4:0]);
          za_d = za_q - atan_lut(cnt_q[4:0]);
        end else begin
          xa_d = xa_q + (ya_q >>> cnt_q[4:0]);
          ya_d = ya_q - (xa_q >>> cnt_q[4:0]);
          za_d = za_q + atan_lut(cnt_q[4:0]);
        end
        if (!zb_q[25]) begin
          xb_d = xb_q - (yb_q >>> cnt_q[4:0]);
          yb_d = yb_q + (xb_q >>> cnt_q[4:0]);
          zb_d = zb_q - atan_lut(cnt_q[4:0]);
        end else begin
          xb_d = xb_q + (yb_q >>> cnt_q[4:0]);
          yb_d = yb_q - (xb_q >>> cnt_q[4:0]);
          zb_d = zb_q + atan_lut(cnt_q[4:0]);
        end
        if (cnt_q == 6'(CordicSteps - 1)) begin
          cnt_d = '0;
          st_d  = StFront;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      // Front vector before normalizing, two products.
      StFront: begin
        mul_b = cb[32:0];
        if (cnt_q == 6'd0) begin
          mul_a = ca[32:0];
          cnt_d = 6'd1;
        end else if (cnt_q == 6'd1) begin
          mul_a    = sa[32:0];
          vec_d[0] = rnd[31:0];
          cnt_d    = 6'd2;
        end else begin
          vec_d[2] = rnd[31:0];
          vec_d[1] = sb[31:0];
          pass_d   = 2'd0;
          cnt_d    = '0;
          acc_d    = '0;
          st_d     = StSq;
        end
      end

      // Sum of squares, one component per cycle.
      StSq: begin
        rd_idx = (cnt_q < 6'd3) ? cnt_q[1:0] : 2'd0;
        mul_a  = $signed(rd_abs);
        mul_b  = $signed(rd_abs);
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + prod_q[63:0];
        end
        if (cnt_q == 6'd3) begin
          n_d   = acc_q + prod_q[63:0];
          res_d = '0;
          bit_d = 64'd1 << 62;
          cnt_d = '0;
          st_d  = StSqrt;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      // Integer square root, one result bit per cycle.
      StSqrt: begin
        if (n_q >= rb) begin
          n_d   = n_q - rb;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cnt_q == 6'd31) begin
          len_d  = res_d[32:0];
          cnt_d  = '0;
          comp_d = '0;
          st_d   = StDiv;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      // Rounded component over length, one quotient bit per cycle.
      StDiv: begin
        if (cnt_q == 6'd0) begin
          if (len_q == '0) begin
            vres_d[pass_q][comp_q] = '0;
            cnt_d = 6'd17;
          end else begin
            rem_d = (50'(rd_abs) << 15) + 50'(len_q);
            quo_d = '0;
            cnt_d = 6'd1;
          end
        end else if (cnt_q <= 6'd16) begin
          if (rem_q >= dsh) begin
            rem_d      = rem_q - dsh;
            quo_d[shk] = 1'b1;
          end
          if (cnt_q == 6'd16) begin
            vres_d[pass_q][comp_q] = rd_v[31] ? -$signed(quo_d) : $signed(quo_d);
          end
          cnt_d = cnt_q + 6'd1;
        end
        if (cnt_q >= 6'd16 || (cnt_q == 6'd0 && len_q == '0)) begin
          cnt_d = '0;
          if (comp_q != 2'd2) begin
            comp_d = comp_q + 2'd1;
          end else begin
            comp_d = '0;
            if (pass_q == 2'd2) begin
              st_d = StOut;
            end else begin
              pass_d = pass_q + 2'd1;
              st_d   = StCross;
            end
          end
        end
      end

      // Cross product: six products, paired into differences.
      StCross: begin
        case (cnt_q)
          6'd0: begin mul_a = 33'(xa_op[1]); mul_b = 33'(xb_op[2]); end
          6'd1: begin mul_a = 33'(xa_op[2]); mul_b = 33'(xb_op[1]); end
          6'd2: begin mul_a = 33'(xa_op[2]); mul_b = 33'(xb_op[0]); end
          6'd3: begin mul_a = 33'(xa_op[0]); mul_b = 33'(xb_op[2]); end
          6'd4: begin mul_a = 33'(xa_op[0]); mul_b = 33'(xb_op[1]); end
          6'd5: begin mul_a = 33'(xa_op[1]); mul_b = 33'(xb_op[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q != 6'd0) begin
          if (!jj[0]) begin
            tmp_d = prod_q[31:0];
          end else begin
            vec_d[jj[2:1]] = tmp_q - prod_q[31:0];
          end
        end
        if (cnt_q == 6'd6) begin
          cnt_d = '0;
          acc_d = '0;
          st_d  = StSq;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      // Hand the result to the output register once it is free.
      StOut: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d = 1'b1;
          for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
              od_d[(p*3+k)*16 +: 16] = vres_q[p][k];
            end
            od_d[144 + p*32 +: 32] = pos_q[p];
          end
          st_d = StIdle;
        end
      end

      default: st_d = StIdle;
    endcase
  end

  // Shared multiplier, registered.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    lim_q  <= lim_d;
    xa_q   <= xa_d;
    ya_q   <= ya_d;
    xb_q   <= xb_d;
    yb_q   <= yb_d;
    za_q   <= za_d;
    zb_q   <= zb_d;
    nga_q  <= nga_d;
    ngb_q  <= ngb_d;
    vec_q  <= vec_d;
    tmp_q  <= tmp_d;
    vres_q <= vres_d;
    acc_q  <= acc_d;
    n_q    <= n_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    len_q  <= len_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    od_q   <= od_d;
    pass_q <= pass_d;
    comp_q <= comp_d;
  end

  // Control and camera state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
      ov_q  <= 1'b0;
      yaw_q <= YawReset;
      pit_q <= '0;
      for (int k = 0; k < 3; k++) begin
        pos_q[k] <= '0;
      end
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
      yaw_q <= yaw_d;
      pit_q <= pit_d;
      pos_q <= pos_d;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;

endmodule

@@ src/euler_camera_orientation.sv @@
// Top level of the Euler camera orientation block.
//
// Input items arrive on the s_axis channel: offsets and move vector in tdata,
// the pitch-limit and absolute-move flags in tuser. Each accepted transfer
// yields exactly one result on the m_axis channel: the unit front, right and
// up vectors in Q2.14 and the camera position in Q16.16.
// Configuration (sensitivity, world up) is written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i and takes effect at once; the user must write
// it only while the block is idle, as the block itself does not enforce it.
// From the queue to the output register an item runs through the back-end
// sequencer: wrapping, eighteen rotation steps, and for each of the three
// normalizations the squaring, a 32-step square root and three 17-step
// divisions. The next item leaves the queue only after the previous result
// has entered the output register and the sequencer is back in idle.
// A two-entry queue lets the front accept up to two further items while one
// is in work. When the receiver stalls, the result stays in the output
// register and the back end waits before writing the next one.
// Reset clears the queue, the output valid, the angles (yaw -90 degrees,
// pitch 0) and the position, and loads the default configuration.
module euler_camera_orientation (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // offset_x, offset_y, move_x, move_y, move_z
  input  logic [127:0] s_axis_tdata,
  // limit_pitch, absolute_move
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // front_x/y/z, right_x/y/z, up_x/y/z, position_x/y/z
  output logic [239:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);
  import ecam_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push, pop, full, empty;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sens <= 16'd6554;
      cfg_q.up_x <= 16'sd0;
      cfg_q.up_y <= 16'sd16384;
      cfg_q.up_z <= 16'sd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSensitivity: cfg_q.sens <= cfg_wdata_i;
        RegUpX:         cfg_q.up_x <= cfg_wdata_i;
        RegUpY:         cfg_q.up_y <= cfg_wdata_i;
        RegUpZ:         cfg_q.up_z <= cfg_wdata_i;
        default:        cfg_q      <= cfg_q;
      endcase
    end
  end

  ecam_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .sens_i          (cfg_q.sens),
    .full_i          (full),
    .push_o          (push),
    .item_o          (push_item)
  );

  ecam_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  ecam_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .empty_i         (empty),
    .item_i          (pop_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

@@ src/ecam_checker.sv @@
// Port-level checks for the Euler camera orientation block, bound to the top.
module ecam_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [239:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The front x and right x components stay within one in Q2.14.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16'sd16384 &&
                       $signed(m_axis_tdata[63:48]) <= 16'sd16384 &&
                       $signed(m_axis_tdata[63:48]) >= -16'sd16384))
    else $error("unit vector component out of range");

  // No result is offered right after reset is released.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result offered at reset release");

endmodule

bind euler_camera_orientation ecam_checker u_ecam_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
